// ===== rtl/core/clock_set_menu_controller_macros.svh =====
`ifndef CLOCK_SET_MENU_CONTROLLER_MACROS_SVH
`define CLOCK_SET_MENU_CONTROLLER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CSMC_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a condition implies another at the same edge.
`define CSMC_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/csmc_pkg.sv =====
package csmc_pkg;

    typedef logic [1:0] button_t;
    typedef logic [1:0] menu_t;
    typedef logic [1:0] field_t;

    localparam button_t BTN_MODE = 2'd0;
    localparam button_t BTN_UP   = 2'd1;
    localparam button_t BTN_DOWN = 2'd2;

    localparam menu_t MENU_TIME    = 2'd0;
    localparam menu_t MENU_DATE    = 2'd1;
    localparam menu_t MENU_COUNTRY = 2'd2;
    localparam menu_t MENU_EXIT    = 2'd3;

    localparam field_t FLD_FIRST  = 2'd0;
    localparam field_t FLD_SECOND = 2'd1;
    localparam field_t FLD_THIRD  = 2'd2;

    localparam logic [4:0]  HOUR_MAX  = 5'd23;
    localparam logic [5:0]  MIN_MAX   = 6'd59;
    localparam logic [5:0]  SEC_MAX   = 6'd59;
    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [3:0]  MONTH_MIN = 4'd1;
    localparam logic [3:0]  MONTH_MAX = 4'd12;
    localparam logic [4:0]  DAY_MIN   = 5'd1;
    localparam logic [4:0]  DAY_MAX   = 5'd31;

endpackage

// ===== rtl/core/clock_set_menu_controller.sv =====
// Three-button menu controller for setting the time, date and country.
// Input channel (item_valid / item_stall): one button press per item
// (mode 0 = mode, 1 = up, 2 = down) with the current clock time and date.
// Output channel (result_valid / result_stall): one result per item with the
// save and exit strobes, menu position, edit flag, field cursor, the edit
// registers and the country selection, all as they stand after the press.
// An item that is taken is registered in the input register, processed and
// then registered in the result register, where result_valid shows it.
// Throughput: one item per cycle while result_stall is low; the menu and
// edit state update in the logic between the input and result registers.
// Reset clears the menu position, edit flag, cursors, country and both valid
// flags; the edit registers hold no meaning until the first entry into edit.
// While result_stall is high the result holds, one more item is taken into
// the input register and item_stall then rises until the result is taken.
`include "clock_set_menu_controller_macros.svh"

module clock_set_menu_controller
    import csmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  mode,
    input  logic [4:0]  cur_hour,
    input  logic [5:0]  cur_minute,
    input  logic [5:0]  cur_second,
    input  logic [13:0] cur_year,
    input  logic [3:0]  cur_month,
    input  logic [4:0]  cur_day,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        save_strobe,
    output logic        exit_strobe,
    output logic [1:0]  menu_item,
    output logic        editing,
    output logic [1:0]  field_cursor,
    output logic [4:0]  set_hour,
    output logic [5:0]  set_minute,
    output logic [5:0]  set_second,
    output logic [13:0] set_year,
    output logic [3:0]  set_month,
    output logic [4:0]  set_day,
    output logic        country_sel
);

    logic        s1_valid_reg;
    button_t     s1_mode_reg;
    logic [4:0]  s1_hour_reg;
    logic [5:0]  s1_minute_reg;
    logic [5:0]  s1_second_reg;
    logic [13:0] s1_year_reg;
    logic [3:0]  s1_month_reg;
    logic [4:0]  s1_day_reg;

    menu_t       menu_pos_reg,    menu_pos_next;
    logic        edit_active_reg, edit_active_next;
    field_t      time_cursor_reg, time_cursor_next;
    field_t      date_cursor_reg, date_cursor_next;
    logic        country_reg,     country_next;
    logic [4:0]  hour_reg,        hour_next;
    logic [5:0]  minute_reg,      minute_next;
    logic [5:0]  second_reg,      second_next;
    logic [13:0] year_reg,        year_next;
    logic [3:0]  month_reg,       month_next;
    logic [4:0]  day_reg,         day_next;

    logic        save_next;
    logic        exit_next;
    field_t      cursor_next;

    logic        out_valid_reg;
    logic        save_reg;
    logic        exit_reg;
    menu_t       menu_out_reg;
    logic        edit_out_reg;
    field_t      cursor_out_reg;
    logic [4:0]  hour_out_reg;
    logic [5:0]  minute_out_reg;
    logic [5:0]  second_out_reg;
    logic [13:0] year_out_reg;
    logic [3:0]  month_out_reg;
    logic [4:0]  day_out_reg;
    logic        country_out_reg;

    logic        advance;
    logic        take;
    logic        fire;

    logic [4:0]  hour_up,   hour_dn;
    logic [5:0]  minute_up, minute_dn;
    logic [5:0]  second_up, second_dn;
    logic [13:0] year_up,   year_dn;
    logic [3:0]  month_up,  month_dn;
    logic [4:0]  day_up,    day_dn;

    assign advance    = !out_valid_reg || !result_stall;
    assign item_stall = s1_valid_reg && !advance;
    assign take       = item_valid && !item_stall;
    assign fire       = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_mode_reg   <= mode;
            s1_hour_reg   <= cur_hour;
            s1_minute_reg <= cur_minute;
            s1_second_reg <= cur_second;
            s1_year_reg   <= cur_year;
            s1_month_reg  <= cur_month;
            s1_day_reg    <= cur_day;
        end
    end

    assign hour_up   = (hour_reg >= HOUR_MAX) ? 5'd0 : hour_reg + 5'd1;
    assign hour_dn   = (hour_reg == 5'd0) ? HOUR_MAX : hour_reg - 5'd1;
    assign minute_up = (minute_reg >= MIN_MAX) ? 6'd0 : minute_reg + 6'd1;
    assign minute_dn = (minute_reg == 6'd0) ? MIN_MAX : minute_reg - 6'd1;
    assign second_up = (second_reg >= SEC_MAX) ? 6'd0 : second_reg + 6'd1;
    assign second_dn = (second_reg == 6'd0) ? SEC_MAX : second_reg - 6'd1;
    assign year_up   = (year_reg < YEAR_MAX) ? year_reg + 14'd1 : year_reg;
    assign year_dn   = (year_reg > 14'd0) ? year_reg - 14'd1 : year_reg;
    assign month_up  = (month_reg >= MONTH_MAX) ? MONTH_MIN : month_reg + 4'd1;
    assign month_dn  = (month_reg <= MONTH_MIN) ? MONTH_MAX : month_reg - 4'd1;
    assign day_up    = (day_reg >= DAY_MAX) ? DAY_MIN : day_reg + 5'd1;
    assign day_dn    = (day_reg <= DAY_MIN) ? DAY_MAX : day_reg - 5'd1;

    always_comb
    begin
        menu_pos_next    = menu_pos_reg;
        edit_active_next = edit_active_reg;
        time_cursor_next = time_cursor_reg;
        date_cursor_next = date_cursor_reg;
        country_next     = country_reg;
        hour_next        = hour_reg;
        minute_next      = minute_reg;
        second_next      = second_reg;
        year_next        = year_reg;
        month_next       = month_reg;
        day_next         = day_reg;
        save_next        = 1'b0;
        exit_next        = 1'b0;

        unique case (s1_mode_reg)
            BTN_MODE:
            begin
                if (!edit_active_reg)
                begin
                    if (menu_pos_reg == MENU_EXIT)
                    begin
                        exit_next = 1'b1;
                    end
                    else
                    begin
                        hour_next   = (s1_hour_reg > HOUR_MAX) ? HOUR_MAX : s1_hour_reg;
                        minute_next = (s1_minute_reg > MIN_MAX) ? MIN_MAX : s1_minute_reg;
                        second_next = (s1_second_reg > SEC_MAX) ? SEC_MAX : s1_second_reg;
                        year_next   = (s1_year_reg > YEAR_MAX) ? YEAR_MAX : s1_year_reg;
                        month_next  = (s1_month_reg < MONTH_MIN) ? MONTH_MIN :
                                      (s1_month_reg > MONTH_MAX) ? MONTH_MAX : s1_month_reg;
                        day_next    = (s1_day_reg < DAY_MIN) ? DAY_MIN : s1_day_reg;
                        time_cursor_next = FLD_FIRST;
                        date_cursor_next = FLD_FIRST;
                        edit_active_next = 1'b1;
                    end
                end
                else
                begin
                    unique case (menu_pos_reg)
                        MENU_TIME:
                        begin
                            if (time_cursor_reg < FLD_THIRD)
                            begin
                                time_cursor_next = time_cursor_reg + 2'd1;
                            end
                            else
                            begin
                                save_next        = 1'b1;
                                time_cursor_next = FLD_FIRST;
                                edit_active_next = 1'b0;
                            end
                        end
                        MENU_DATE:
                        begin
                            if (date_cursor_reg < FLD_THIRD)
                            begin
                                date_cursor_next = date_cursor_reg + 2'd1;
                            end
                            else
                            begin
                                save_next        = 1'b1;
                                date_cursor_next = FLD_FIRST;
                                edit_active_next = 1'b0;
                            end
                        end
                        MENU_COUNTRY:
                        begin
                            edit_active_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BTN_UP, BTN_DOWN:
            begin
                if (!edit_active_reg)
                begin
                    if (s1_mode_reg == BTN_UP && menu_pos_reg != MENU_TIME)
                    begin
                        menu_pos_next = menu_pos_reg - 2'd1;
                    end
                    else if (s1_mode_reg == BTN_DOWN && menu_pos_reg != MENU_EXIT)
                    begin
                        menu_pos_next = menu_pos_reg + 2'd1;
                    end
                end
                else
                begin
                    unique case (menu_pos_reg)
                        MENU_TIME:
                        begin
                            unique case (time_cursor_reg)
                                FLD_FIRST:
                                    hour_next = (s1_mode_reg == BTN_UP) ? hour_up : hour_dn;
                                FLD_SECOND:
                                    minute_next = (s1_mode_reg == BTN_UP) ? minute_up
                                                                          : minute_dn;
                                FLD_THIRD:
                                    second_next = (s1_mode_reg == BTN_UP) ? second_up
                                                                          : second_dn;
                                default:
                                begin
                                end
                            endcase
                        end
                        MENU_DATE:
                        begin
                            unique case (date_cursor_reg)
                                FLD_FIRST:
                                    year_next = (s1_mode_reg == BTN_UP) ? year_up : year_dn;
                                FLD_SECOND:
                                    month_next = (s1_mode_reg == BTN_UP) ? month_up : month_dn;
                                FLD_THIRD:
                                    day_next = (s1_mode_reg == BTN_UP) ? day_up : day_dn;
                                default:
                                begin
                                end
                            endcase
                        end
                        MENU_COUNTRY:
                        begin
                            country_next = !country_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase

        unique case (menu_pos_next)
            MENU_TIME: cursor_next = time_cursor_next;
            MENU_DATE: cursor_next = date_cursor_next;
            default:   cursor_next = FLD_FIRST;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            menu_pos_reg    <= MENU_TIME;
            edit_active_reg <= 1'b0;
            time_cursor_reg <= FLD_FIRST;
            date_cursor_reg <= FLD_FIRST;
            country_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                menu_pos_reg    <= menu_pos_next;
                edit_active_reg <= edit_active_next;
                time_cursor_reg <= time_cursor_next;
                date_cursor_reg <= date_cursor_next;
                country_reg     <= country_next;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            hour_reg        <= hour_next;
            minute_reg      <= minute_next;
            second_reg      <= second_next;
            year_reg        <= year_next;
            month_reg       <= month_next;
            day_reg         <= day_next;
            save_reg        <= save_next;
            exit_reg        <= exit_next;
            menu_out_reg    <= menu_pos_next;
            edit_out_reg    <= edit_active_next;
            cursor_out_reg  <= cursor_next;
            hour_out_reg    <= hour_next;
            minute_out_reg  <= minute_next;
            second_out_reg  <= second_next;
            year_out_reg    <= year_next;
            month_out_reg   <= month_next;
            day_out_reg     <= day_next;
            country_out_reg <= country_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign save_strobe  = save_reg;
    assign exit_strobe  = exit_reg;
    assign menu_item    = menu_out_reg;
    assign editing      = edit_out_reg;
    assign field_cursor = cursor_out_reg;
    assign set_hour     = hour_out_reg;
    assign set_minute   = minute_out_reg;
    assign set_second   = second_out_reg;
    assign set_year     = year_out_reg;
    assign set_month    = month_out_reg;
    assign set_day      = day_out_reg;
    assign country_sel  = country_out_reg;

    `CSMC_ALWAYS(a_edit_not_on_exit, !(edit_active_reg && menu_pos_reg == MENU_EXIT), "edit active on exit item")
    `CSMC_IMPLIES(a_strobes_exclusive, out_valid_reg, !(save_reg && exit_reg), "save and exit strobes together")
    `CSMC_IMPLIES(a_save_leaves_edit, out_valid_reg && save_reg, !edit_out_reg && cursor_out_reg == FLD_FIRST, "save strobe while still editing")
    `CSMC_IMPLIES(a_exit_from_menu, out_valid_reg && exit_reg, !edit_out_reg && menu_out_reg == MENU_EXIT, "exit strobe away from exit item")
    `CSMC_IMPLIES(a_stall_only_full, item_stall, s1_valid_reg && out_valid_reg && result_stall, "input stalled with room free")

endmodule
